// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files that carry concurrent checks.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the expected consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the condition.
`define KNPS_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequence must hold in the cycle after the condition.
`define KNPS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/knps_pkg.sv =====
// ----------------------------------------------------------------------------
// knps_pkg
// Shared constants and controller/datapath interface types for the
// k nearest point selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package knps_pkg;

  localparam int DEF_MAX_KEEP = 3;
  localparam int DEF_ID_BITS  = 16;

  localparam int COORD_W = 16;              // point and reference coordinates
  localparam int DIFF_W  = COORD_W + 1;     // coordinate difference
  localparam int SQ_W    = 2 * COORD_W;     // one squared axis distance
  localparam int DIST_W  = SQ_W + 1;        // sum of both axes
  localparam int KEEP_W  = 2;               // keep count register
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_X = 2'd0,
    CFG_REF_Y = 2'd1,
    CFG_KEEP  = 2'd2
  } knps_cfg_idx_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;   // take the accepted item
    logic square;    // square both axis differences
    logic sum;       // add the squares
    logic update;    // fill or replace a slot
    logic wscan;     // one step of the worst-slot search
    logic escan;     // one step of the next-smallest search
    logic push;      // load the output stage
  } knps_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic wrote;      // update wrote a slot
    logic last;       // held item ends the pass
    logic empty;      // no slot in use
    logic scan_last;  // scan index is at the last used slot
    logic out_free;   // output stage can take a result
    logic pass_end;   // the pending result is the final one
  } knps_sts_t;

endpackage

`default_nettype wire

// ===== src/knps_datapath.sv =====
// ----------------------------------------------------------------------------
// knps_datapath
// Distance arithmetic, slot store, worst-slot and ordered-output searches,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knps_datapath #(
  parameter int MAX_KEEP = 3,
  parameter int ID_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [knps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [knps_pkg::COORD_W-1:0]      cfg_data,
  input  wire logic signed [knps_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [knps_pkg::COORD_W-1:0] point_y,
  input  wire logic [ID_BITS-1:0]                point_id,
  input  wire logic                              point_skip,
  input  wire logic                              point_last,
  input  wire knps_pkg::knps_cmd_t               cmd,
  output knps_pkg::knps_sts_t                    sts,
  output logic [ID_BITS-1:0]                     res_id,
  output logic [knps_pkg::DIST_W-1:0]            res_dist,
  output logic                                   res_found,
  output logic                                   res_last,
  output logic                                   res_valid,
  input  wire logic                              res_ready
);
  import knps_pkg::*;

  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int KW    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  // configuration
  logic signed [COORD_W-1:0] ref_x_r, ref_y_r;
  logic [KEEP_W-1:0]         keep_r;

  // item pipeline
  logic signed [DIFF_W-1:0]  dx_r, dy_r;
  logic [ID_BITS-1:0]        pid_r;
  logic                      skip_r, last_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic [DIST_W-1:0]         dnew_r;

  // slot store
  logic [DIST_W-1:0]         slot_dist_r [MAX_KEEP];
  logic [ID_BITS-1:0]        slot_id_r   [MAX_KEEP];
  logic [CNT_W-1:0]          used_r;
  logic [IDX_W-1:0]          worst_r;
  logic [DIST_W-1:0]         worst_dist_r;

  // searches
  logic [IDX_W-1:0]          scan_i_r;
  logic [MAX_KEEP-1:0]       emitted_r;
  logic [CNT_W-1:0]          emit_cnt_r;
  logic [IDX_W-1:0]          best_r;
  logic [DIST_W-1:0]         best_dist_r;
  logic [ID_BITS-1:0]        best_id_r;
  logic                      have_r;

  logic [DIFF_W-1:0]         ax_full, ay_full;
  logic [KW-1:0]             keep_w, max_w, keep_eff, used_w;
  logic                      fill, repl, scan_last, empty, pass_end, out_free;
  logic [IDX_W-1:0]          wr_idx;
  logic [DIST_W-1:0]         cur_dist;
  logic [ID_BITS-1:0]        cur_id;

  always_comb begin
    ax_full = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
    ay_full = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
  end

  // keep count saturated to the store depth
  always_comb begin
    keep_w   = KW'(keep_r);
    max_w    = KW'(MAX_KEEP);
    keep_eff = (keep_w > max_w) ? max_w : keep_w;
    used_w   = KW'(used_r);
  end

  assign empty     = (used_r == '0);
  assign fill      = !skip_r && (keep_eff != '0) && (used_w < keep_eff);
  assign repl      = !skip_r && (keep_eff != '0) && !fill && !empty &&
                     (dnew_r < worst_dist_r);
  assign wr_idx    = fill ? used_r[IDX_W-1:0] : worst_r;
  assign scan_last = ((CNT_W'(scan_i_r) + CNT_W'(1)) == used_r);
  assign pass_end  = empty || ((emit_cnt_r + CNT_W'(1)) == used_r);
  assign out_free  = !res_valid || res_ready;
  assign cur_dist  = slot_dist_r[scan_i_r];
  assign cur_id    = slot_id_r[scan_i_r];

  always_comb begin
    sts.wrote     = fill || repl;
    sts.last      = last_r;
    sts.empty     = empty;
    sts.scan_last = scan_last;
    sts.out_free  = out_free;
    sts.pass_end  = pass_end;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
      keep_r  <= KEEP_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REF_X: ref_x_r <= cfg_data;
        CFG_REF_Y: ref_y_r <= cfg_data;
        CFG_KEEP:  keep_r  <= cfg_data[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // arithmetic pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dx_r   <= DIFF_W'(point_x) - DIFF_W'(ref_x_r);
      dy_r   <= DIFF_W'(point_y) - DIFF_W'(ref_y_r);
      pid_r  <= point_id;
      skip_r <= point_skip;
      last_r <= point_last;
    end
    if (cmd.square) begin
      sqx_r <= ax_full[COORD_W-1:0] * ax_full[COORD_W-1:0];
      sqy_r <= ay_full[COORD_W-1:0] * ay_full[COORD_W-1:0];
    end
    if (cmd.sum) begin
      dnew_r <= DIST_W'(sqx_r) + DIST_W'(sqy_r);
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (cmd.update && (fill || repl)) begin
      slot_dist_r[wr_idx] <= dnew_r;
      slot_id_r[wr_idx]   <= pid_r;
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    if (cmd.wscan && ((scan_i_r == '0) || (cur_dist > worst_dist_r))) begin
      worst_dist_r <= cur_dist;
    end
    if (cmd.escan && !emitted_r[scan_i_r] && (!have_r || (cur_dist < best_dist_r))) begin
      best_r      <= scan_i_r;
      best_dist_r <= cur_dist;
      best_id_r   <= cur_id;
    end
    if (cmd.push) begin
      res_id    <= empty ? '0 : best_id_r;
      res_dist  <= empty ? '0 : best_dist_r;
      res_found <= !empty;
      res_last  <= pass_end;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      worst_r    <= '0;
      scan_i_r   <= '0;
      emitted_r  <= '0;
      emit_cnt_r <= '0;
      have_r     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd.update && fill) begin
        used_r <= used_r + CNT_W'(1);
      end
      if (cmd.wscan) begin
        if ((scan_i_r == '0) || (cur_dist > worst_dist_r)) begin
          worst_r <= scan_i_r;
        end
        scan_i_r <= scan_last ? '0 : scan_i_r + IDX_W'(1);
      end
      if (cmd.escan) begin
        if (!emitted_r[scan_i_r] && (!have_r || (cur_dist < best_dist_r))) begin
          have_r <= 1'b1;
        end
        scan_i_r <= scan_last ? '0 : scan_i_r + IDX_W'(1);
      end
      if (cmd.push) begin
        res_valid <= 1'b1;
        have_r    <= 1'b0;
        if (pass_end) begin
          // clear the store for the next pass
          used_r     <= '0;
          worst_r    <= '0;
          emitted_r  <= '0;
          emit_cnt_r <= '0;
        end else begin
          emitted_r[best_r] <= 1'b1;
          emit_cnt_r        <= emit_cnt_r + CNT_W'(1);
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/knps_ctrl.sv =====
// ----------------------------------------------------------------------------
// knps_ctrl
// Sequencer for one item: difference, square, sum, slot update, worst-slot
// search, and on the last item the ordered output loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knps_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output knps_pkg::knps_cmd_t      cmd,
  input  wire knps_pkg::knps_sts_t sts
);
  import knps_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQR   = 7'b0000010,
    ST_SUM   = 7'b0000100,
    ST_UPD   = 7'b0001000,
    ST_WSCAN = 7'b0010000,
    ST_ESCAN = 7'b0100000,
    ST_EPUSH = 7'b1000000
  } knps_state_t;

  knps_state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.capture = in_valid && in_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        if (sts.wrote) begin
          state_nxt = ST_WSCAN;
        end else if (sts.last) begin
          state_nxt = sts.empty ? ST_EPUSH : ST_ESCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WSCAN: begin
        cmd.wscan = 1'b1;
        if (sts.scan_last) state_nxt = sts.last ? ST_ESCAN : ST_IDLE;
      end
      ST_ESCAN: begin
        cmd.escan = 1'b1;
        if (sts.scan_last) state_nxt = ST_EPUSH;
      end
      ST_EPUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = sts.pass_end ? ST_IDLE : ST_ESCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/k_nearest_point_selector_top.sv =====
// ----------------------------------------------------------------------------
// k_nearest_point_selector_top
// Keeps the up to MAX_KEEP candidates closest to a reference point by exact
// squared distance and emits them in ascending order at the end of a pass.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   in_      slave      in_tvalid / in_tready     tdata x,y,id; tuser skip; tlast
//   out_     master     out_tvalid / out_tready   tdata id,dist; tuser found; tlast
//   cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An item passes through capture, square, sum and slot update when no slot
// changes, and through the serial worst-slot search over the store as well
// when it fills or replaces a slot.
// The last item of a pass adds, per result, one search over the store plus
// the push into the output register, or the push alone for a not-found
// result; the push waits while out_tready holds the output register.
// The final result waits in the output register while the next item enters.
// Reset (rst_n low, synchronous) empties the store and sets ref_x 0, ref_y 0,
// keep_count 3. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module k_nearest_point_selector_top #(
  parameter int MAX_KEEP = knps_pkg::DEF_MAX_KEEP,
  parameter int ID_BITS  = knps_pkg::DEF_ID_BITS,
  parameter int IN_W     = ((2 * knps_pkg::COORD_W + ID_BITS + 7) / 8) * 8,
  parameter int OUT_W    = ((ID_BITS + knps_pkg::DIST_W + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input items
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [IN_W-1:0]                in_tdata,   // point_x, point_y, point_id
  input  wire logic [0:0]                     in_tuser,   // skip
  input  wire logic                           in_tlast,   // last_point
  // result items
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [OUT_W-1:0]                    out_tdata,  // near_id, near_dist_sq
  output logic [0:0]                          out_tuser,  // found
  output logic                                out_tlast,  // last_result
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [knps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [knps_pkg::COORD_W-1:0]   cfg_data
);
  import knps_pkg::*;

  knps_cmd_t              cmd;
  knps_sts_t              sts;
  logic [ID_BITS-1:0]     res_id;
  logic [DIST_W-1:0]      res_dist;

  // Registers are plain flops: accept a write every cycle.
  assign cfg_ready = 1'b1;

  knps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  knps_datapath #(
    .MAX_KEEP (MAX_KEEP),
    .ID_BITS  (ID_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .point_x    (in_tdata[COORD_W-1:0]),
    .point_y    (in_tdata[2*COORD_W-1:COORD_W]),
    .point_id   (in_tdata[2*COORD_W+ID_BITS-1:2*COORD_W]),
    .point_skip (in_tuser[0]),
    .point_last (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .res_id     (res_id),
    .res_dist   (res_dist),
    .res_found  (out_tuser[0]),
    .res_last   (out_tlast),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready)
  );

  // Pack id low, distance above it, zero fill to the byte boundary.
  assign out_tdata = OUT_W'({res_dist, res_id});

  // The block takes no second item until the first is through the update.
  `KNPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // A not-found result always closes its pass.
  `KNPS_ASSERT_IMPL(a_not_found_is_last, clk, rst_n, out_tvalid && !out_tuser[0], out_tlast)
  // The controller never overwrites a result that is still waiting.
  `KNPS_ASSERT_IMPL(a_push_when_free, clk, rst_n, cmd.push, sts.out_free)

endmodule

`default_nettype wire

// ===== sim/k_nearest_point_selector_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_point_selector_top_tb
// Streams candidate points through the selector and checks every result item
// against an in-bench scoring model. A short directed plan covers the field
// extremes, fill and replace, ties, empty passes and keep count changes, then
// random passes run with random idling on both streams.
// ----------------------------------------------------------------------------

module k_nearest_point_selector_top_tb;
  import knps_pkg::*;

  localparam int KEEP_MAX    = 3;
  localparam int IN_W        = 48;   // x, y, id packed to whole bytes
  localparam int OUT_W       = 56;   // id, dist packed to whole bytes
  localparam int SETTLE      = 16;   // worst item latency with margin
  localparam int STALL_LIMIT = 4000; // cycles with no handshake at all
  localparam int RAND_POINTS = 155;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [15:0]               id;
    logic                      skip;
    logic                      last;
  } point_t;

  typedef struct {
    logic [15:0]       id;
    logic [DIST_W-1:0] dsq;
    logic              found;
    logic              last;
  } near_t;

  // One directed step: either a register write or a candidate point; the
  // result of a point row is typed in only where it is obvious.
  typedef struct {
    logic          is_cfg;
    knps_cfg_idx_t reg_idx;
    logic [15:0]   reg_val;
    point_t        pt;
    logic          typed;
    near_t         want;
  } step_t;

  logic clk;
  logic rst_n;

  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // point_x, point_y, point_id
  logic [0:0]            in_tuser;   // skip
  logic                  in_tlast;   // last_point

  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // near_id, near_dist_sq
  logic [0:0]            out_tuser;  // found
  logic                  out_tlast;  // last_result

  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COORD_W-1:0]    cfg_data;

  // Scoring model state: reference point, keep count and the kept slots.
  logic signed [COORD_W-1:0] anchor_x;
  logic signed [COORD_W-1:0] anchor_y;
  logic [KEEP_W-1:0]         keep_lim;
  logic [DIST_W-1:0]         held_dist [KEEP_MAX];
  logic [15:0]               held_id   [KEEP_MAX];
  int                        held_cnt;
  int                        worst_idx;

  near_t  nearest_q [$];   // results still owed by the block
  step_t  plan [$];
  int     errors;
  int     idle_cycles;
  int     fresh_points;
  bit     steady;          // no idling on either stream while set
  near_t  seen_want;

  k_nearest_point_selector_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scoring model
  // --------------------------------------------------------------------------

  // Append one owed result at the tail of the queue.
  function automatic void owe_result(near_t r);
    nearest_q.insert(nearest_q.size(), r);
  endfunction

  // Append one directed step at the tail of the plan.
  function automatic void plan_add(step_t s);
    plan.insert(plan.size(), s);
  endfunction

  // Squared distance along one axis; the 17-bit difference magnitude fits
  // 16 bits, so the square fits 32 bits exactly.
  function automatic logic [31:0] axis_sq(logic signed [COORD_W-1:0] a,
                                          logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        mag;
    logic [31:0]             m32;
    d   = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    mag = d[COORD_W] ? -d : d;
    m32 = {16'b0, mag[COORD_W-1:0]};
    return m32 * m32;
  endfunction

  // The worst slot is the first one holding the largest distance.
  function automatic void find_worst_slot();
    worst_idx = 0;
    for (int i = 1; i < held_cnt; i++) begin
      if (held_dist[i] > held_dist[worst_idx]) worst_idx = i;
    end
  endfunction

  // Score one accepted point; on the last point of a pass queue the kept
  // entries in ascending distance (ties in slot order) unless told to hold.
  task automatic rank_point(input point_t p, input bit emit);
    logic [DIST_W-1:0] d;
    int order [KEEP_MAX];
    int n, j, s;
    if (!p.skip && keep_lim != 0) begin
      d = {1'b0, axis_sq(p.x, anchor_x)} + {1'b0, axis_sq(p.y, anchor_y)};
      if (held_cnt < int'(keep_lim) && held_cnt < KEEP_MAX) begin
        held_dist[held_cnt] = d;
        held_id[held_cnt]   = p.id;
        held_cnt++;
        find_worst_slot();
      end else if (held_cnt > 0 && d < held_dist[worst_idx]) begin
        held_dist[worst_idx] = d;
        held_id[worst_idx]   = p.id;
        find_worst_slot();
      end
    end
    if (!p.last) return;
    n = held_cnt;
    if (emit) begin
      if (n == 0) begin
        owe_result('{16'd0, '0, 1'b0, 1'b1});
      end else begin
        for (int i = 0; i < n; i++) begin
          s = i;
          j = i;
          while (j > 0 && held_dist[order[j-1]] > held_dist[s]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = s;
        end
        for (int i = 0; i < n; i++)
          owe_result('{held_id[order[i]], held_dist[order[i]], 1'b1, (i == n - 1)});
      end
    end
    held_cnt  = 0;
    worst_idx = 0;
  endtask

  // --------------------------------------------------------------------------
  // Drivers: all start and end at a falling edge
  // --------------------------------------------------------------------------

  // Offer one point, idling at random first, and score it once it is taken.
  // Leave tvalid high so back-to-back points need no re-raise.
  task automatic send_point(input point_t p, input bit typed, input near_t want);
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {p.id, p.y, p.x};
    in_tuser  = p.skip;
    in_tlast  = p.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rank_point(p, !typed);
    if (typed) owe_result(want);
    @(negedge clk);
  endtask

  // Hold until every owed result is back, then let the block drain.
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (nearest_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write one register, only while the block is idle.
  task automatic write_reg(input knps_cfg_idx_t idx, input logic [15:0] val);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_REF_X: anchor_x = val;
      CFG_REF_Y: anchor_y = val;
      CFG_KEEP:  keep_lim = val[KEEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic step_t pt_step(logic [15:0] x, logic [15:0] y, logic [15:0] id,
                                    logic skip, logic last);
    step_t s;
    s.is_cfg  = 1'b0;
    s.reg_idx = CFG_REF_X;
    s.reg_val = '0;
    s.pt      = '{x, y, id, skip, last};
    s.typed   = 1'b0;
    s.want    = '{16'd0, '0, 1'b0, 1'b0};
    return s;
  endfunction

  function automatic step_t cfg_step(knps_cfg_idx_t idx, logic [15:0] val);
    step_t s;
    s         = pt_step(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t typed_step(logic [15:0] x, logic [15:0] y, logic [15:0] id,
                                       logic skip, logic [15:0] w_id,
                                       logic [DIST_W-1:0] w_dist, logic w_found);
    step_t s;
    s       = pt_step(x, y, id, skip, 1'b1);
    s.typed = 1'b1;
    s.want  = '{w_id, w_dist, w_found, 1'b1};
    return s;
  endfunction

  // Random coordinate: mostly a few steps off the reference so that ties and
  // replacements are frequent, otherwise anywhere or at an extreme.
  function automatic logic [15:0] pick_coord(logic [15:0] center);
    int r;
    r = $urandom_range(99);
    if (r < 55) return center + 16'($urandom_range(6)) - 16'd3;
    if (r < 85) return 16'($urandom);
    case ($urandom_range(2))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_ref();
    if ($urandom_range(99) < 40) return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
    return 16'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: compare each taken item with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (nearest_q.size() == 0) begin
        $error("unexpected result item: near_id %0d near_dist_sq %0d",
               out_tdata[15:0], out_tdata[16 +: DIST_W]);
        errors++;
      end else begin
        seen_want = nearest_q.pop_front();
        if (out_tdata[15:0] !== seen_want.id) begin
          $error("near_id: expected %0d, got %0d", seen_want.id, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[16 +: DIST_W] !== seen_want.dsq) begin
          $error("near_dist_sq: expected %0d, got %0d", seen_want.dsq,
                 out_tdata[16 +: DIST_W]);
          errors++;
        end
        if (out_tuser[0] !== seen_want.found) begin
          $error("found: expected %0b, got %0b", seen_want.found, out_tuser[0]);
          errors++;
        end
        if (out_tlast !== seen_want.last) begin
          $error("last_result: expected %0b, got %0b", seen_want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Receiver: stall about a third of the cycles unless in a steady stretch.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = steady || ($urandom_range(99) >= 33);
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[k_nearest_point_selector_top] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    point_t p;
    near_t  none;
    int     n_pass;
    int     pass_len;
    int     pass_no;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    in_tlast    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_REF_X;
    cfg_data    = '0;
    errors      = 0;
    idle_cycles = 0;
    steady      = 1'b0;
    none        = '{16'd0, '0, 1'b0, 1'b0};

    // Model reset state matches the block after reset.
    anchor_x  = '0;
    anchor_y  = '0;
    keep_lim  = 2'd3;
    held_cnt  = 0;
    worst_idx = 0;

    // Directed plan. Reference starts at the origin, keep count 3.
    // Empty pass: one skipped last point gives a single not-found result.
    plan_add(typed_step(16'h1234, 16'h5678, 16'h0001, 1'b1, 16'd0, '0, 1'b0));
    // Corner points against the origin, id extremes.
    plan_add(typed_step(16'h8000, 16'h8000, 16'hFFFF, 1'b0,
                        16'hFFFF, 33'd2147483648, 1'b1));
    plan_add(typed_step(16'h7FFF, 16'h7FFF, 16'h0000, 1'b0,
                        16'h0000, 33'd2147352578, 1'b1));
    // Largest distance: reference at the top corner, point at the bottom one.
    plan_add(cfg_step(CFG_REF_X, 16'h7FFF));
    plan_add(cfg_step(CFG_REF_Y, 16'h7FFF));
    plan_add(typed_step(16'h8000, 16'h8000, 16'h8001, 1'b0,
                        16'h8001, 33'd8589672450, 1'b1));
    // Fill, replace the worst, refuse an equal distance, ignore a skip.
    plan_add(pt_step(16'd32760, 16'd32760, 16'd10, 1'b0, 1'b0));
    plan_add(pt_step(16'd32767, 16'd32767, 16'd11, 1'b0, 1'b0));
    plan_add(pt_step(16'd32757, 16'd32767, 16'd12, 1'b0, 1'b0));
    plan_add(pt_step(16'd32758, 16'd32764, 16'd13, 1'b0, 1'b0));
    plan_add(pt_step(16'd32760, 16'd32760, 16'd14, 1'b0, 1'b0));
    plan_add(pt_step(16'd32767, 16'd32767, 16'd15, 1'b1, 1'b0));
    plan_add(pt_step(16'd32763, 16'd32767, 16'd16, 1'b0, 1'b1));
    // Equal distances come out in slot order.
    plan_add(pt_step(16'd32766, 16'd32767, 16'd20, 1'b0, 1'b0));
    plan_add(pt_step(16'd32767, 16'd32766, 16'd21, 1'b0, 1'b1));
    // Zero keep count with an empty store: not found.
    plan_add(cfg_step(CFG_KEEP, 16'd0));
    plan_add(typed_step(16'd0, 16'd0, 16'd30, 1'b0, 16'd0, '0, 1'b0));
    // Keep one: the closer point replaces the single entry.
    plan_add(cfg_step(CFG_KEEP, 16'd1));
    plan_add(pt_step(16'd32767, 16'd32700, 16'd40, 1'b0, 1'b0));
    plan_add(pt_step(16'd32767, 16'd32766, 16'd41, 1'b0, 1'b1));
    // Keep count lowered mid pass: held entries stay, only replacement runs.
    plan_add(cfg_step(CFG_KEEP, 16'd3));
    plan_add(pt_step(16'd32767, 16'd32760, 16'd50, 1'b0, 1'b0));
    plan_add(pt_step(16'd32767, 16'd32765, 16'd51, 1'b0, 1'b0));
    plan_add(cfg_step(CFG_KEEP, 16'd1));
    plan_add(pt_step(16'd32767, 16'd32766, 16'd52, 1'b0, 1'b0));
    plan_add(pt_step(16'd32767, 16'd32767, 16'd53, 1'b0, 1'b1));
    // Zero keep count mid pass: the held entry is still emitted.
    plan_add(cfg_step(CFG_KEEP, 16'd3));
    plan_add(pt_step(16'd32767, 16'd32767, 16'd60, 1'b0, 1'b0));
    plan_add(cfg_step(CFG_KEEP, 16'd0));
    plan_add(pt_step(16'd0, 16'd0, 16'd61, 1'b0, 1'b1));
    // Reference at the bottom corner; skipped last point still ends the pass.
    plan_add(cfg_step(CFG_REF_X, 16'h8000));
    plan_add(cfg_step(CFG_REF_Y, 16'h8000));
    plan_add(cfg_step(CFG_KEEP, 16'd3));
    plan_add(typed_step(16'h7FFF, 16'h7FFF, 16'hFFFE, 1'b0,
                        16'hFFFE, 33'd8589672450, 1'b1));
    plan_add(pt_step(16'h8000, 16'h8000, 16'd70, 1'b0, 1'b0));
    plan_add(pt_step(16'h8000, 16'h8000, 16'd71, 1'b1, 1'b1));

    // Hold reset, then release it at a falling edge.
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_point(plan[i].pt, plan[i].typed, plan[i].want);
      end
    end

    // Random passes: mostly well-formed passes with a few skips, registers
    // rewritten between passes and now and then the keep count mid pass.
    // Every random point sent counts toward the total.
    fresh_points = 0;
    pass_no      = 0;
    while (fresh_points < RAND_POINTS) begin
      if ($urandom_range(99) < 35) begin
        case ($urandom_range(2))
          0:       write_reg(CFG_REF_X, pick_ref());
          1:       write_reg(CFG_REF_Y, pick_ref());
          default: write_reg(CFG_KEEP, ($urandom_range(99) < 15) ? 16'($urandom) & 16'hFFFC
                                                                 : 16'($urandom) | 16'h0001);
        endcase
      end
      // Hold off once until every owed result is back.
      if (pass_no == 6) drain_results();
      pass_len = $urandom_range(1, 8);
      for (n_pass = 0; n_pass < pass_len; n_pass++) begin
        if (n_pass > 0 && $urandom_range(99) < 6)
          write_reg(CFG_KEEP, 16'($urandom));
        steady = (fresh_points >= 70 && fresh_points < 110);
        p.x    = pick_coord(anchor_x);
        p.y    = pick_coord(anchor_y);
        p.id   = 16'($urandom);
        p.skip = ($urandom_range(99) < 12);
        p.last = (n_pass == pass_len - 1);
        fresh_points++;
        send_point(p, 1'b0, none);
      end
      pass_no++;
    end
    steady = 1'b0;

    // Wait for the last owed results, then keep idling to catch strays.
    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("[k_nearest_point_selector_top] OK");
    end else begin
      $display("[k_nearest_point_selector_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/knps_pkg.sv
src/knps_datapath.sv
src/knps_ctrl.sv
src/k_nearest_point_selector_top.sv
sim/k_nearest_point_selector_top_tb.sv
